### design/srl_pkg.sv
package srl_pkg;

    localparam int TableEntries = 4096;
    localparam int TableWays    = 4;
    localparam int NumSets      = TableEntries / TableWays;
    localparam int SetBits      = $clog2(NumSets);
    localparam int WayBits      = $clog2(TableWays);

    localparam logic [31:0] DefaultLimit  = 32'd200;
    localparam logic [63:0] DefaultWindow = 64'd2000000000;
    localparam logic [15:0] MinFrame      = 16'd54;
    localparam logic [15:0] EthIpv4       = 16'h0800;
    localparam logic [7:0]  ProtoTcp      = 8'd6;

    localparam logic [2:0] OUT_NOT_SYN   = 3'd0;
    localparam logic [2:0] OUT_NEW       = 3'd1;
    localparam logic [2:0] OUT_RESTART   = 3'd2;
    localparam logic [2:0] OUT_WITHIN    = 3'd3;
    localparam logic [2:0] OUT_OVER      = 3'd4;

    localparam logic [0:0] REG_RATE_LIMIT = 1'd0;
    localparam logic [0:0] REG_WINDOW_LEN = 1'd1;

    // One table slot
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [63:0] start;
        logic [31:0] count;
    } slot_t;

    typedef slot_t [TableWays-1:0] set_slots_t;
    typedef logic [TableWays-1:0][WayBits-1:0] ranks_t;

    function automatic ranks_t reset_ranks();
        ranks_t r;
        for (int w = 0; w < TableWays; w++) begin
            r[w] = WayBits'(w);
        end
        return r;
    endfunction

endpackage

### design/srl_set_ram.sv
// Set memory: one row per set, one read and one write port, registered read.
module srl_set_ram (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [srl_pkg::SetBits-1:0]      waddr,
    input  srl_pkg::set_slots_t              wslots,
    input  srl_pkg::ranks_t                  wranks,
    input  logic [srl_pkg::SetBits-1:0]      raddr,
    output srl_pkg::set_slots_t              rslots,
    output srl_pkg::ranks_t                  rranks
);
    srl_pkg::set_slots_t mem_slots [srl_pkg::NumSets];
    srl_pkg::ranks_t     mem_ranks [srl_pkg::NumSets];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_slots[waddr] <= wslots;
            mem_ranks[waddr] <= wranks;
        end
        rslots <= mem_slots[raddr];
        rranks <= mem_ranks[raddr];
    end
endmodule

### design/syn_rate_limiter_per_source.sv
// Per-source SYN rate limiter. Each header on s_axis yields one verdict on m_axis.
// An item is read from the set memory in the cycle after its transfer. A SYN item
// is updated and written back in that same cycle, and the item's verdict sits in
// the result register from the next cycle. A new header is taken only once the
// result register is empty, so the block finishes one item before it takes the
// next: transfer, read-modify-write, result transfer. A low m_tready holds s_tready
// low until the verdict has gone out. After reset a clearing pass writes all 1024
// sets, one per cycle, while s_tready is low.
module syn_rate_limiter_per_source (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] captured_len, [31:16] ether_type, [39:32] ip_proto, [40] syn_flag,
    // [41] ack_flag, [73:42] source_addr, [137:74] arrival_time, rest zero
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] drop, [3:1] outcome, [35:4] window_count, rest zero
    output logic [39:0]  m_tdata
);
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [srl_pkg::SetBits-1:0] clr_reg;
    logic [31:0]                 limit_reg;
    logic [63:0]                 window_reg;
    logic                        syn_reg;
    logic [31:0]                 addr_reg;
    logic [63:0]                 now_reg;
    logic [srl_pkg::SetBits-1:0] set_reg;
    logic                        ovalid_reg;
    logic [35:0]                 odata_reg;

    // Config port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[3])
            srl_pkg::REG_RATE_LIMIT: prdata = {32'd0, limit_reg};
            default:                 prdata = window_reg;
        endcase
    end

    // Input decode
    logic [15:0] in_len, in_et;
    logic [7:0]  in_pr;
    logic [31:0] in_addr;
    logic        in_syn;
    logic [15:0] fold;
    assign in_len  = s_tdata[15:0];
    assign in_et   = s_tdata[31:16];
    assign in_pr   = s_tdata[39:32];
    assign in_addr = s_tdata[73:42];
    assign in_syn  = (in_len >= srl_pkg::MinFrame) && (in_et == srl_pkg::EthIpv4) &&
                     (in_pr == srl_pkg::ProtoTcp) && s_tdata[40] && !s_tdata[41];
    assign fold    = in_addr[31:16] ^ in_addr[15:0];

    logic in_acc;
    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign in_acc   = s_tvalid && s_tready;

    // Memory
    srl_pkg::set_slots_t rslots, wslots;
    srl_pkg::ranks_t     rranks, wranks;
    logic                we;
    logic [srl_pkg::SetBits-1:0] waddr;

    srl_set_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wslots(wslots), .wranks(wranks),
        .raddr(fold[srl_pkg::SetBits-1:0]), .rslots(rslots), .rranks(rranks)
    );

    // Lookup and update
    logic                        hit, anyfree;
    logic [srl_pkg::WayBits-1:0] hway, fway, lway, way;
    logic [31:0]                 lim, cnt;
    logic                        expired;
    srl_pkg::set_slots_t         uslots;
    srl_pkg::ranks_t             uranks;
    logic [2:0]                  outc;
    logic [31:0]                 wcount;

    always_comb begin
        hit = 1'b0; hway = '0; anyfree = 1'b0; fway = '0; lway = '0;
        for (int w = srl_pkg::TableWays - 1; w >= 0; w--) begin
            if (rslots[w].valid && rslots[w].addr == addr_reg) begin
                hit = 1'b1;
                hway = srl_pkg::WayBits'(w);
            end
            if (!rslots[w].valid) begin
                anyfree = 1'b1;
                fway = srl_pkg::WayBits'(w);
            end
        end
        for (int w = 0; w < srl_pkg::TableWays; w++) begin
            if (rranks[w] == srl_pkg::WayBits'(srl_pkg::TableWays - 1)) begin
                lway = srl_pkg::WayBits'(w);
            end
        end
        way = hit ? hway : (anyfree ? fway : lway);
        lim = (limit_reg == 32'd0) ? srl_pkg::DefaultLimit : limit_reg;
        expired = (now_reg - rslots[way].start) > window_reg;
        cnt = (rslots[way].count == 32'hFFFF_FFFF) ? rslots[way].count
                                                   : rslots[way].count + 32'd1;
        uslots = rslots;
        uranks = rranks;
        for (int w = 0; w < srl_pkg::TableWays; w++) begin
            if (rranks[w] < rranks[way]) begin
                uranks[w] = rranks[w] + srl_pkg::WayBits'(1);
            end
        end
        uranks[way] = '0;
        if (!hit || expired) begin
            uslots[way] = '{valid: 1'b1, addr: addr_reg, start: now_reg, count: 32'd1};
            outc   = hit ? srl_pkg::OUT_RESTART : srl_pkg::OUT_NEW;
            wcount = 32'd1;
        end else begin
            uslots[way].count = cnt;
            outc   = (cnt > lim) ? srl_pkg::OUT_OVER : srl_pkg::OUT_WITHIN;
            wcount = cnt;
        end
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            we = 1'b1; waddr = clr_reg; wslots = '0; wranks = srl_pkg::reset_ranks();
        end else begin
            we = (state_reg == ST_READ) && syn_reg;
            waddr = set_reg; wslots = uslots; wranks = uranks;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == srl_pkg::SetBits'(srl_pkg::NumSets - 1))
                          state_next = ST_IDLE;
            ST_IDLE:  if (in_acc) state_next = ST_READ;
            ST_READ:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            limit_reg  <= 32'd0;
            window_reg <= srl_pkg::DefaultWindow;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_wr) begin
                if (paddr[3] == srl_pkg::REG_RATE_LIMIT) limit_reg <= pwdata[31:0];
                else window_reg <= pwdata;
            end
            if (state_reg == ST_READ) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            syn_reg  <= in_syn;
            addr_reg <= in_addr;
            now_reg  <= s_tdata[137:74];
            set_reg  <= fold[srl_pkg::SetBits-1:0];
        end
        if (state_reg == ST_READ) begin
            odata_reg <= syn_reg ? {wcount, outc, outc == srl_pkg::OUT_OVER}
                                 : {32'd0, srl_pkg::OUT_NOT_SYN, 1'b0};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, odata_reg};

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !s_tready) else $error("accept while busy");
    a_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> m_tvalid) else $error("result missing");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready) else $error("accept in clear");
endmodule
